### rtl/core/fdep_pkg.sv
package fdep_pkg;

    // long-name storage bound and derived sizes
    localparam int LONG_MAX   = 4;
    localparam int UNITS      = 13;
    localparam int NAME_DEPTH = LONG_MAX * UNITS;
    localparam int NAME_AW    = $clog2(NAME_DEPTH);
    localparam int SEG_W      = $clog2(LONG_MAX + 1);
    localparam int SEG_IW     = (LONG_MAX > 1) ? $clog2(LONG_MAX) : 1;
    localparam int LEN_W      = $clog2(UNITS + 1);
    localparam int SHORT_LEN  = 11;
    localparam int SHORT_IW   = $clog2(SHORT_LEN + 1);

    // marker bytes and characters
    localparam logic [7:0] BYTE_END        = 8'h00;
    localparam logic [7:0] BYTE_DELETED    = 8'hE5;
    localparam logic [7:0] BYTE_DOT        = 8'h2E;
    localparam logic [7:0] BYTE_FF         = 8'hFF;
    localparam logic [7:0] ATTR_LONG       = 8'h0F;
    localparam logic [7:0] ATTR_NODOT_MASK = 8'h18;
    localparam logic [7:0] CHAR_SPACE      = 8'h20;
    localparam logic [7:0] CHAR_PERIOD     = 8'h2E;

    // controller to datapath
    typedef struct packed {
        logic take;
        logic start;
        logic l_read;
        logic l_push;
        logic l_next_seg;
        logic s_step;
        logic finish;
    } fdep_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic short_done;
        logic lng;
        logic l_has;
        logic l_seg_zero;
        logic s_done;
        logic out_free;
    } fdep_status_t;

    // entry offset that completes a utf-16 unit of a long-name entry
    function automatic logic unit_hi(input logic [4:0] pos);
        unit_hi = pos inside {5'd2, 5'd4, 5'd6, 5'd8, 5'd10, 5'd15, 5'd17,
                              5'd19, 5'd21, 5'd23, 5'd25, 5'd29, 5'd31};
    endfunction

endpackage

### rtl/core/fdep_ctrl.sv
module fdep_ctrl
    import fdep_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  fdep_status_t st,
    output fdep_cmd_t    cmd,
    output logic         in_stall
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LSCAN,
        ST_LUSE,
        ST_SSCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.take = in_valid;
                if (st.short_done)
                begin
                    cmd.start  = 1'b1;
                    state_next = st.lng ? ST_LSCAN : ST_SSCAN;
                end
            end
            ST_LSCAN:
            begin
                if (st.l_has)
                begin
                    cmd.l_read = 1'b1;
                    state_next = ST_LUSE;
                end
                else if (st.l_seg_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.l_next_seg = 1'b1;
                end
            end
            ST_LUSE:
            begin
                if (st.out_free)
                begin
                    cmd.l_push = 1'b1;
                    state_next = ST_LSCAN;
                end
            end
            ST_SSCAN:
            begin
                if (st.s_done)
                begin
                    state_next = ST_FINISH;
                end
                else if (st.out_free)
                begin
                    cmd.s_step = 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

endmodule

### rtl/core/fdep_dp.sv
module fdep_dp
    import fdep_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic [7:0]   data_byte,
    input  logic         restart,
    input  logic         out_stall,
    input  fdep_cmd_t    cmd,
    output fdep_status_t st,
    output logic         out_valid,
    output logic [7:0]   name_char,
    output logic         last,
    output logic [5:0]   attributes,
    output logic [31:0]  first_cluster,
    output logic [31:0]  size_bytes,
    output logic         long_name,
    output logic         name_truncated,
    output logic [15:0]  slot_index
);

    localparam logic [4:0] POS_ATTR = 5'd11;
    localparam logic [4:0] POS_LAST = 5'd31;

    // entry collection state
    logic [4:0]         pos_reg, pos_next;
    logic               ended_reg, ended_next;
    logic [15:0]        slot_reg, slot_next;
    logic [SEG_W-1:0]   count_reg, count_next;
    logic               ovf_reg, ovf_next;
    logic [NAME_AW-1:0] seg_base_reg, seg_base_next;
    logic [LEN_W-1:0]   seg_len_reg [LONG_MAX];
    logic [LEN_W-1:0]   seg_len_next [LONG_MAX];
    logic               stop_reg, stop_next;
    logic [LEN_W-1:0]   unit_n_reg, unit_n_next;
    logic [7:0]         prev_reg, prev_next;

    // entry bytes kept for the short name and metadata
    logic [7:0]         name_bytes_reg [SHORT_LEN];
    logic [7:0]         attr_reg;
    logic [31:0]        cluster_reg;
    logic [31:0]        size_reg;

    // long-name store
    logic [7:0]         name_mem [NAME_DEPTH];
    logic [7:0]         rd_data_reg;
    logic               mem_we;
    logic [NAME_AW-1:0] mem_waddr;
    logic [NAME_AW-1:0] rd_addr;

    // emission state
    logic [SEG_IW-1:0]  emit_seg_reg, emit_seg_next;
    logic [NAME_AW-1:0] emit_base_reg, emit_base_next;
    logic [SHORT_IW-1:0] emit_i_reg, emit_i_next;
    logic               dot_reg, dot_next;
    logic               lng_reg, lng_next;
    logic               trunc_reg, trunc_next;
    logic [15:0]        emit_slot_reg, emit_slot_next;
    logic               pend_valid_reg, pend_valid_next;
    logic [7:0]         pend_char_reg, pend_char_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [7:0]         out_char_reg, out_char_next;
    logic               out_last_reg, out_last_next;
    logic [5:0]         out_attr_reg, out_attr_next;
    logic [31:0]        out_cluster_reg, out_cluster_next;
    logic [31:0]        out_size_reg, out_size_next;
    logic               out_long_reg, out_long_next;
    logic               out_trunc_reg, out_trunc_next;
    logic [15:0]        out_slot_reg, out_slot_next;

    logic               byte_we;
    logic [4:0]         wr_pos;
    logic               short_done;
    logic               lng_any;
    logic [LEN_W-1:0]   seg_len_cur;
    logic [7:0]         short_byte;
    logic               push_en;
    logic [7:0]         push_char;
    logic [SEG_W-1:0]   count_m1;

    // status toward the controller
    always_comb
    begin
        lng_any = 1'b0;
        for (int e = 0; e < LONG_MAX; e++)
        begin
            lng_any = lng_any | (seg_len_reg[e] != '0);
        end
    end

    assign seg_len_cur = seg_len_reg[emit_seg_reg];
    assign short_byte  = (emit_i_reg < SHORT_IW'(SHORT_LEN))
                         ? name_bytes_reg[emit_i_reg] : BYTE_END;

    assign st.short_done = short_done;
    assign st.lng        = lng_any;
    assign st.l_has      = (emit_i_reg != seg_len_cur);
    assign st.l_seg_zero = (emit_seg_reg == '0);
    assign st.s_done     = (emit_i_reg == SHORT_IW'(SHORT_LEN)) || (short_byte == BYTE_END);
    assign st.out_free   = !out_valid_reg || !out_stall;

    assign count_m1 = count_reg - SEG_W'(1);
    assign rd_addr  = NAME_AW'(emit_base_reg + NAME_AW'(emit_i_reg));

    // collection, emission and output next state
    always_comb
    begin
        pos_next        = pos_reg;
        ended_next      = ended_reg;
        slot_next       = slot_reg;
        count_next      = count_reg;
        ovf_next        = ovf_reg;
        seg_base_next   = seg_base_reg;
        seg_len_next    = seg_len_reg;
        stop_next       = stop_reg;
        unit_n_next     = unit_n_reg;
        prev_next       = prev_reg;
        emit_seg_next   = emit_seg_reg;
        emit_base_next  = emit_base_reg;
        emit_i_next     = emit_i_reg;
        dot_next        = dot_reg;
        lng_next        = lng_reg;
        trunc_next      = trunc_reg;
        emit_slot_next  = emit_slot_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        out_attr_next   = out_attr_reg;
        out_cluster_next = out_cluster_reg;
        out_size_next   = out_size_reg;
        out_long_next   = out_long_reg;
        out_trunc_next  = out_trunc_reg;
        out_slot_next   = out_slot_reg;
        byte_we         = 1'b0;
        wr_pos          = pos_reg;
        short_done      = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = seg_base_reg;
        push_en         = 1'b0;
        push_char       = BYTE_END;

        // incoming byte
        if (cmd.take)
        begin
            if (restart)
            begin
                pos_next      = '0;
                ended_next    = 1'b0;
                slot_next     = '0;
                count_next    = '0;
                ovf_next      = 1'b0;
                seg_base_next = '0;
                for (int e = 0; e < LONG_MAX; e++)
                begin
                    seg_len_next[e] = '0;
                end
            end
            if (!ended_next)
            begin
                byte_we = 1'b1;
                wr_pos  = pos_next;
                if (wr_pos == '0)
                begin
                    stop_next   = 1'b0;
                    unit_n_next = '0;
                end
                // long-name unit, low byte is the previous one
                if (unit_hi(wr_pos) && !stop_next)
                begin
                    if ((prev_reg == BYTE_END && data_byte == BYTE_END) ||
                        (prev_reg == BYTE_FF && data_byte == BYTE_FF))
                    begin
                        stop_next = 1'b1;
                    end
                    else if (prev_reg != BYTE_END)
                    begin
                        mem_we      = (count_next < SEG_W'(LONG_MAX));
                        mem_waddr   = NAME_AW'(seg_base_next + NAME_AW'(unit_n_next));
                        unit_n_next = unit_n_next + LEN_W'(1);
                    end
                end
                prev_next = data_byte;
                pos_next  = wr_pos + 5'd1;
                // entry complete
                if (wr_pos == POS_LAST)
                begin
                    if (name_bytes_reg[0] == BYTE_END)
                    begin
                        ended_next = 1'b1;
                    end
                    else
                    begin
                        if (name_bytes_reg[0] != BYTE_DELETED && name_bytes_reg[0] != BYTE_DOT)
                        begin
                            if (attr_reg == ATTR_LONG)
                            begin
                                if (count_next < SEG_W'(LONG_MAX))
                                begin
                                    seg_len_next[count_next[SEG_IW-1:0]] = unit_n_next;
                                    count_next    = count_next + SEG_W'(1);
                                    seg_base_next = NAME_AW'(seg_base_next + NAME_AW'(UNITS));
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                            end
                            else
                            begin
                                short_done = 1'b1;
                            end
                        end
                        if (slot_next != 16'hFFFF)
                        begin
                            slot_next = slot_next + 16'd1;
                        end
                    end
                end
            end
        end

        // start of a name
        if (cmd.start)
        begin
            emit_seg_next   = count_m1[SEG_IW-1:0];
            emit_base_next  = NAME_AW'(seg_base_reg - NAME_AW'(UNITS));
            emit_i_next     = '0;
            dot_next        = ((attr_reg & ATTR_NODOT_MASK) == BYTE_END);
            lng_next        = lng_any;
            trunc_next      = ovf_reg;
            emit_slot_next  = slot_reg;
            pend_valid_next = 1'b0;
        end

        // walk long-name segments, newest first
        if (cmd.l_next_seg)
        begin
            emit_seg_next  = emit_seg_reg - SEG_IW'(1);
            emit_base_next = NAME_AW'(emit_base_reg - NAME_AW'(UNITS));
            emit_i_next    = '0;
        end
        if (cmd.l_push)
        begin
            push_en     = 1'b1;
            push_char   = rd_data_reg;
            emit_i_next = emit_i_reg + SHORT_IW'(1);
        end

        // 8.3 name character
        if (cmd.s_step)
        begin
            emit_i_next = emit_i_reg + SHORT_IW'(1);
            if (short_byte == CHAR_SPACE)
            begin
                if (dot_reg)
                begin
                    push_en   = 1'b1;
                    push_char = CHAR_PERIOD;
                    dot_next  = 1'b0;
                end
            end
            else
            begin
                push_en   = 1'b1;
                push_char = short_byte;
            end
        end

        // one-character hold so the final beat can be marked
        if (push_en)
        begin
            if (pend_valid_reg)
            begin
                out_valid_next   = 1'b1;
                out_char_next    = pend_char_reg;
                out_last_next    = 1'b0;
                out_attr_next    = '0;
                out_cluster_next = '0;
                out_size_next    = '0;
                out_long_next    = lng_reg;
                out_trunc_next   = trunc_reg;
                out_slot_next    = '0;
            end
            pend_valid_next = 1'b1;
            pend_char_next  = push_char;
        end

        // final beat with metadata, then drop the long-name collection
        if (cmd.finish)
        begin
            out_valid_next   = 1'b1;
            out_char_next    = pend_valid_reg ? pend_char_reg : BYTE_END;
            out_last_next    = 1'b1;
            out_attr_next    = attr_reg[5:0];
            out_cluster_next = cluster_reg;
            out_size_next    = size_reg;
            out_long_next    = lng_reg;
            out_trunc_next   = trunc_reg;
            out_slot_next    = emit_slot_reg;
            pend_valid_next  = 1'b0;
            count_next       = '0;
            ovf_next         = 1'b0;
            seg_base_next    = '0;
            for (int e = 0; e < LONG_MAX; e++)
            begin
                seg_len_next[e] = '0;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            ended_reg      <= 1'b0;
            slot_reg       <= '0;
            count_reg      <= '0;
            ovf_reg        <= 1'b0;
            seg_base_reg   <= '0;
            stop_reg       <= 1'b0;
            unit_n_reg     <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            for (int e = 0; e < LONG_MAX; e++)
            begin
                seg_len_reg[e] <= '0;
            end
        end
        else
        begin
            pos_reg        <= pos_next;
            ended_reg      <= ended_next;
            slot_reg       <= slot_next;
            count_reg      <= count_next;
            ovf_reg        <= ovf_next;
            seg_base_reg   <= seg_base_next;
            stop_reg       <= stop_next;
            unit_n_reg     <= unit_n_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            seg_len_reg    <= seg_len_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prev_reg        <= prev_next;
        emit_seg_reg    <= emit_seg_next;
        emit_base_reg   <= emit_base_next;
        emit_i_reg      <= emit_i_next;
        dot_reg         <= dot_next;
        lng_reg         <= lng_next;
        trunc_reg       <= trunc_next;
        emit_slot_reg   <= emit_slot_next;
        pend_char_reg   <= pend_char_next;
        out_char_reg    <= out_char_next;
        out_last_reg    <= out_last_next;
        out_attr_reg    <= out_attr_next;
        out_cluster_reg <= out_cluster_next;
        out_size_reg    <= out_size_next;
        out_long_reg    <= out_long_next;
        out_trunc_reg   <= out_trunc_next;
        out_slot_reg    <= out_slot_next;
    end

    // entry byte capture
    always_ff @(posedge clk)
    begin
        if (byte_we)
        begin
            if (wr_pos < 5'(SHORT_LEN))
            begin
                name_bytes_reg[wr_pos[SHORT_IW-1:0]] <= data_byte;
            end
            case (wr_pos)
                POS_ATTR: attr_reg            <= data_byte;
                5'd20:    cluster_reg[23:16]  <= data_byte;
                5'd21:    cluster_reg[31:24]  <= data_byte;
                5'd26:    cluster_reg[7:0]    <= data_byte;
                5'd27:    cluster_reg[15:8]   <= data_byte;
                5'd28:    size_reg[7:0]       <= data_byte;
                5'd29:    size_reg[15:8]      <= data_byte;
                5'd30:    size_reg[23:16]     <= data_byte;
                5'd31:    size_reg[31:24]     <= data_byte;
                default:
                begin
                end
            endcase
        end
    end

    // long-name store, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            name_mem[mem_waddr] <= prev_reg;
        end
        if (cmd.l_read)
        begin
            rd_data_reg <= name_mem[rd_addr];
        end
    end

    assign out_valid      = out_valid_reg;
    assign name_char      = out_char_reg;
    assign last           = out_last_reg;
    assign attributes     = out_attr_reg;
    assign first_cluster  = out_cluster_reg;
    assign size_bytes     = out_size_reg;
    assign long_name      = out_long_reg;
    assign name_truncated = out_trunc_reg;
    assign slot_index     = out_slot_reg;

endmodule

### rtl/core/fat_directory_entry_parser.sv
// channel | signals                                        | direction
// in      | in_valid, in_stall, data_byte, restart          | byte stream in
// out     | out_valid, out_stall, name_char, last, metadata | one name character per beat
//
// one byte is taken each cycle while entries are gathered and skipped
// a long-name entry never stalls the input: its units are stored as the bytes arrive
// after a short entry the input stalls while its name is sent: each long-name
// character is a registered read of the name store followed by a push, each 8.3
// name byte is a step of the scan, each long-name segment and the 8.3 scan end
// with a closing step, then the final beat follows; out_stall can hold any push
// reset is asynchronous; the entry and name stores need no clearing pass
module fat_directory_entry_parser
    import fdep_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        restart,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  name_char,
    output logic        last,
    output logic [5:0]  attributes,
    output logic [31:0] first_cluster,
    output logic [31:0] size_bytes,
    output logic        long_name,
    output logic        name_truncated,
    output logic [15:0] slot_index
);

    fdep_cmd_t    cmd;
    fdep_status_t st;

    // sequencer
    fdep_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .st       (st),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // entry gathering, name store and output register
    fdep_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .data_byte      (data_byte),
        .restart        (restart),
        .out_stall      (out_stall),
        .cmd            (cmd),
        .st             (st),
        .out_valid      (out_valid),
        .name_char      (name_char),
        .last           (last),
        .attributes     (attributes),
        .first_cluster  (first_cluster),
        .size_bytes     (size_bytes),
        .long_name      (long_name),
        .name_truncated (name_truncated),
        .slot_index     (slot_index)
    );

    // a completed short entry holds off the input while its name goes out
    a_stall_after_short: assert property (@(posedge clk) disable iff (!rst_n)
        st.short_done |=> in_stall)
        else $error("input not stalled after short entry");

    // the final beat follows the finish step
    a_finish_last: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> (out_valid && last))
        else $error("finish did not produce a final beat");

    // metadata only on the final beat
    a_meta_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !last) |-> (attributes == '0 && first_cluster == '0 &&
                                  size_bytes == '0 && slot_index == '0))
        else $error("metadata on a non-final beat");

endmodule
